[hdl/plm_pkg.sv]
// Shared types, widths and constants of the Phong light accumulator.
package plm_pkg;

   localparam int VEC_W    = 63;   // packed x,y,z vector
   localparam int COMP_W   = 21;   // one signed Q4.16 component
   localparam int COL_W    = 48;   // packed r,g,b colour
   localparam int CH_W     = 16;   // one Q1.15 channel
   localparam int SUM_W    = 32;   // Q16.16 accumulator
   localparam int RAD_W    = 45;   // sum of squares
   localparam int ROOT_W   = 23;   // floor square root
   localparam int DVD_W    = 38;   // dividend of a normalization
   localparam int QUOT_W   = 17;   // quotient of a normalization
   localparam int CSR_IDX_W = 3;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_RED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_GREEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_BLUE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPECULAR_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHININESS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LUMEN_GAIN    = 3'd5;

   localparam logic [SUM_W-1:0] SAT32 = 32'hFFFF_FFFF;
   localparam logic [CH_W:0]    ONE_Q15 = 17'd32768;
   localparam logic [QUOT_W-1:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic [CH_W-1:0] ambient_red;
      logic [CH_W-1:0] ambient_green;
      logic [CH_W-1:0] ambient_blue;
      logic [CH_W-1:0] specular_gain;
      logic [7:0]      shininess;
      logic [CH_W-1:0] lumen_gain;
   } plm_cfg_type;

   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } plm_result_type;

   typedef struct packed {
      logic              start_sqrt;
      logic              start_div;
      logic [RAD_W-1:0]  radicand;
      logic [DVD_W-1:0]  dividend;
      logic [ROOT_W-1:0] divisor;
   } plm_dsu_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
      logic [QUOT_W-1:0] quotient;
   } plm_dsu_rsp_type;

endpackage

[hdl/plm_req_if.sv]
// Input channel: one light seen from one surface hit.
interface plm_req_if;
   import plm_pkg::*;
   logic              valid;
   logic              ready;
   logic [VEC_W-1:0]  hit_point;
   logic [VEC_W-1:0]  surface_normal;
   logic [VEC_W-1:0]  ray_dir;
   logic [VEC_W-1:0]  light_pos;
   logic [COL_W-1:0]  light_colour;
   logic [CH_W-1:0]   light_ratio;
   logic [COL_W-1:0]  albedo;
   logic              shadowed;
   logic              last_light;

   modport source (output valid, hit_point, surface_normal, ray_dir, light_pos,
                   light_colour, light_ratio, albedo, shadowed, last_light,
                   input ready);
   modport sink (input valid, hit_point, surface_normal, ray_dir, light_pos,
                 light_colour, light_ratio, albedo, shadowed, last_light,
                 output ready);
endinterface

[hdl/plm_rsp_if.sv]
// Result channel: final clamped colour of one hit.
interface plm_rsp_if;
   import plm_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_red;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

[hdl/phong_light_accumulator.sv]
// The work of an unshadowed light is dominated by the two normalizations (23-step
//   square root and 17-step divide per component in the shared unit) and the
//   shininess-long power loop on the shared multiplier.
// A shadowed light goes straight to the final state; a last light adds the ambient and albedo steps.
// One light transaction at a time; the result register lets the next light enter.
// Synchronous active-high reset clears the accumulators and loads register defaults.
module phong_light_accumulator (
   input  logic                           clock,
   input  logic                           reset,
   plm_req_if.sink                        req_if,
   plm_rsp_if.source                      rsp_if,
   input  logic                           csr_write_enable,
   input  logic [plm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plm_pkg::CH_W-1:0]       csr_write_data
);
   import plm_pkg::*;

   plm_cfg_type    cfg_ff, cfg_in;
   plm_result_type result;
   logic           rsp_free;
   logic           out_valid_ff, out_valid_in;
   logic [CH_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_AMBIENT_RED:   cfg_in.ambient_red   = csr_write_data;
            REG_AMBIENT_GREEN: cfg_in.ambient_green = csr_write_data;
            REG_AMBIENT_BLUE:  cfg_in.ambient_blue  = csr_write_data;
            REG_SPECULAR_GAIN: cfg_in.specular_gain = csr_write_data;
            REG_SHININESS:     cfg_in.shininess     = csr_write_data[7:0];
            REG_LUMEN_GAIN:    cfg_in.lumen_gain    = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   plm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .cfg      (cfg_ff),
      .rsp_free (rsp_free),
      .result   (result)
   );

   // Hold the result until the sink takes it
   assign rsp_free = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      if (result.valid && rsp_free) begin
         out_valid_in = 1'b1;
         red_in       = result.red;
         green_in     = result.green;
         blue_in      = result.blue;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ambient_red   <= 16'd0;
         cfg_ff.ambient_green <= 16'd0;
         cfg_ff.ambient_blue  <= 16'd0;
         cfg_ff.specular_gain <= 16'd16384;
         cfg_ff.shininess     <= 8'd64;
         cfg_ff.lumen_gain    <= 16'd12288;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_red   = red_ff;
   assign rsp_if.out_green = green_ff;
   assign rsp_if.out_blue  = blue_ff;

endmodule

[hdl/plm_dsu.sv]
// Iterative square root and divide unit built around one shared subtractor.
module plm_dsu (
   input  logic                     clock,
   input  logic                     reset,
   input  plm_pkg::plm_dsu_req_type dsu_req,
   output plm_pkg::plm_dsu_rsp_type dsu_rsp
);
   import plm_pkg::*;

   localparam logic MODE_SQRT = 1'b0;
   localparam logic MODE_DIV  = 1'b1;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mode_ff, mode_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [45:0] a_ff, a_in;      // remainder
   logic [45:0] r_ff, r_in;      // root or quotient
   logic [45:0] aux_ff, aux_in;  // root bit or shifted divisor
   logic [45:0] b_side;
   logic [46:0] diff;
   logic        ge;

   // Shared compare and subtract
   always_comb begin
      b_side = (mode_ff == MODE_SQRT) ? (r_ff + aux_ff) : aux_ff;
      diff   = {1'b0, a_ff} - {1'b0, b_side};
      ge     = ~diff[46];
   end

   // Sequence one step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      aux_in  = aux_ff;
      if (dsu_req.start_sqrt) begin
         mode_in = MODE_SQRT;
         busy_in = 1'b1;
         cnt_in  = 5'(ROOT_W - 1);
         a_in    = 46'(dsu_req.radicand);
         r_in    = '0;
         aux_in  = 46'(1) << (2 * (ROOT_W - 1));
      end else if (dsu_req.start_div) begin
         mode_in = MODE_DIV;
         busy_in = 1'b1;
         cnt_in  = 5'(QUOT_W - 1);
         a_in    = 46'(dsu_req.dividend);
         r_in    = '0;
         aux_in  = 46'(dsu_req.divisor) << (QUOT_W - 1);
      end else if (busy_ff) begin
         if (ge) begin
            a_in = diff[45:0];
         end
         if (mode_ff == MODE_SQRT) begin
            r_in   = ge ? ((r_ff >> 1) + aux_ff) : (r_ff >> 1);
            aux_in = aux_ff >> 2;
         end else begin
            r_in   = {r_ff[44:0], ge};
            aux_in = aux_ff >> 1;
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      r_ff    <= r_in;
      aux_ff  <= aux_in;
   end

   assign dsu_rsp.done     = done_ff;
   assign dsu_rsp.root     = r_ff[ROOT_W-1:0];
   assign dsu_rsp.quotient = r_ff[QUOT_W-1:0];

endmodule

[hdl/plm_core.sv]
// Light sequencer with the shared multiplier and the colour accumulator.
module plm_core (
   input  logic                    clock,
   input  logic                    reset,
   plm_req_if.sink                 req_if,
   input  plm_pkg::plm_cfg_type    cfg,
   input  logic                    rsp_free,
   output plm_pkg::plm_result_type result
);
   import plm_pkg::*;

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_SQ        = 5'd1;
   localparam logic [4:0] ST_ROOT_GO   = 5'd2;
   localparam logic [4:0] ST_ROOT_WAIT = 5'd3;
   localparam logic [4:0] ST_DIV_GO    = 5'd4;
   localparam logic [4:0] ST_DIV_WAIT  = 5'd5;
   localparam logic [4:0] ST_DOT_D     = 5'd6;
   localparam logic [4:0] ST_D_FIN     = 5'd7;
   localparam logic [4:0] ST_RF        = 5'd8;
   localparam logic [4:0] ST_DOT_S     = 5'd9;
   localparam logic [4:0] ST_S_FIN     = 5'd10;
   localparam logic [4:0] ST_POW       = 5'd11;
   localparam logic [4:0] ST_FAC       = 5'd12;
   localparam logic [4:0] ST_BRIGHT    = 5'd13;
   localparam logic [4:0] ST_C1        = 5'd14;
   localparam logic [4:0] ST_C2        = 5'd15;
   localparam logic [4:0] ST_FINAL     = 5'd16;
   localparam logic [4:0] ST_AMB       = 5'd17;
   localparam logic [4:0] ST_ALB       = 5'd18;
   localparam logic [4:0] ST_EMIT      = 5'd19;

   // Signed divide by 65536, truncating toward zero
   function automatic logic signed [65:0] div_q16(input logic signed [65:0] x);
      logic signed [65:0] bias;
      bias = x[65] ? 66'sd65535 : 66'sd0;
      return (x + bias) >>> 16;
   endfunction

   logic [4:0]         state_ff, state_in;
   logic [1:0]         k_ff, k_in;
   logic               vsel_ff, vsel_in;
   logic               last_ff, last_in;
   logic signed [20:0] nrm_ff [3], nrm_in [3];
   logic signed [21:0] ld_ff [3], ld_in [3];
   logic signed [21:0] vw_ff [3], vw_in [3];
   logic signed [17:0] lu_ff [3], lu_in [3];
   logic signed [17:0] vu_ff [3], vu_in [3];
   logic signed [29:0] rf_ff [3], rf_in [3];
   logic [CH_W-1:0]    col_ff [3], col_in [3];
   logic [CH_W-1:0]    alb_ff [3], alb_in [3];
   logic [CH_W-1:0]    out_ff [3], out_in [3];
   logic [SUM_W-1:0]   sum_ff [3], sum_in [3];
   logic [CH_W-1:0]    ratio_ff, ratio_in;
   logic signed [49:0] acc_ff, acc_in;
   logic [ROOT_W-1:0]  len_ff, len_in;
   logic signed [22:0] d_ff, d_in;
   logic [16:0]        s_ff, s_in;
   logic [16:0]        p_ff, p_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic [23:0]        factor_ff, factor_in;
   logic [31:0]        bright_ff, bright_in;
   logic [24:0]        c1_ff, c1_in;
   logic [31:0]        tot_ff, tot_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [65:0] q16;
   logic signed [21:0] cur, cur_mag;
   logic [21:0]        kd;
   logic [32:0]        sat_sum;
   logic [31:0]        alb_prod;
   logic [CH_W-1:0]    amb_k;
   logic               accept;
   logic               advance;
   plm_dsu_req_type    dsu_req;
   plm_dsu_rsp_type    dsu_rsp;

   plm_dsu u_dsu (
      .clock   (clock),
      .reset   (reset),
      .dsu_req (dsu_req),
      .dsu_rsp (dsu_rsp)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // Select operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ: begin
            mul_a = vsel_ff ? 33'(vw_ff[k_ff]) : 33'(ld_ff[k_ff]);
            mul_b = mul_a;
         end
         ST_DOT_D: begin
            mul_a = 33'(lu_ff[k_ff]);
            mul_b = 33'(nrm_ff[k_ff]);
         end
         ST_RF: begin
            mul_a = 33'(d_ff);
            mul_b = 33'(nrm_ff[k_ff]);
         end
         ST_DOT_S: begin
            mul_a = 33'(vu_ff[k_ff]);
            mul_b = 33'(rf_ff[k_ff]);
         end
         ST_POW: begin
            mul_a = 33'(p_ff);
            mul_b = 33'(s_ff);
         end
         ST_FAC: begin
            mul_a = 33'(p_ff);
            mul_b = 33'(cfg.specular_gain);
         end
         ST_BRIGHT: begin
            mul_a = 33'(ratio_ff);
            mul_b = 33'(cfg.lumen_gain);
         end
         ST_C1: begin
            mul_a = 33'(factor_ff);
            mul_b = 33'(col_ff[k_ff]);
         end
         ST_C2: begin
            mul_a = 33'(c1_ff);
            mul_b = 33'(bright_ff);
         end
         ST_ALB: begin
            mul_a = 33'(tot_ff);
            mul_b = 33'(alb_ff[k_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // Ambient channel for the current index
   always_comb begin
      case (k_ff)
         2'd0:    amb_k = cfg.ambient_red;
         2'd1:    amb_k = cfg.ambient_green;
         default: amb_k = cfg.ambient_blue;
      endcase
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      vsel_in   = vsel_ff;
      last_in   = last_ff;
      ratio_in  = ratio_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      d_in      = d_ff;
      s_in      = s_ff;
      p_in      = p_ff;
      cnt_in    = cnt_ff;
      factor_in = factor_ff;
      bright_in = bright_ff;
      c1_in     = c1_ff;
      tot_in    = tot_ff;
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = nrm_ff[i];
         ld_in[i]  = ld_ff[i];
         vw_in[i]  = vw_ff[i];
         lu_in[i]  = lu_ff[i];
         vu_in[i]  = vu_ff[i];
         rf_in[i]  = rf_ff[i];
         col_in[i] = col_ff[i];
         alb_in[i] = alb_ff[i];
         out_in[i] = out_ff[i];
         sum_in[i] = sum_ff[i];
      end
      dsu_req  = '0;
      advance  = 1'b0;
      q16      = div_q16(66'(acc_ff));
      cur      = vsel_ff ? vw_ff[k_ff] : ld_ff[k_ff];
      cur_mag  = cur[21] ? -cur : cur;
      kd       = d_ff[22] ? 22'd0 : d_ff[21:0];
      sat_sum  = '0;
      alb_prod = prod[47:16];

      case (state_ff)
         ST_IDLE: begin
            // Capture the transaction and form the two raw directions
            if (accept) begin
               for (int i = 0; i < 3; i++) begin
                  nrm_in[i] = $signed(req_if.surface_normal[i*COMP_W +: COMP_W]);
                  ld_in[i]  = 22'($signed(req_if.light_pos[i*COMP_W +: COMP_W]))
                            - 22'($signed(req_if.hit_point[i*COMP_W +: COMP_W]));
                  vw_in[i]  = -22'($signed(req_if.ray_dir[i*COMP_W +: COMP_W]));
                  col_in[i] = req_if.light_colour[i*CH_W +: CH_W];
                  alb_in[i] = req_if.albedo[i*CH_W +: CH_W];
               end
               ratio_in = req_if.light_ratio;
               last_in  = req_if.last_light;
               k_in     = 2'd0;
               vsel_in  = 1'b0;
               state_in = req_if.shadowed ? ST_FINAL : ST_SQ;
            end
         end
         ST_SQ: begin
            acc_in = ((k_ff == 2'd0) ? 50'sd0 : acc_ff) + $signed(prod[49:0]);
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = ST_ROOT_GO;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_ROOT_GO: begin
            dsu_req.start_sqrt = 1'b1;
            dsu_req.radicand   = acc_ff[RAD_W-1:0];
            state_in           = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (dsu_rsp.done) begin
               len_in   = dsu_rsp.root;
               k_in     = 2'd0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            // Zero length: unit vector is all zero
            if (len_ff == '0) begin
               if (vsel_ff) vu_in[k_ff] = '0;
               else         lu_in[k_ff] = '0;
               advance = 1'b1;
            end else begin
               dsu_req.start_div = 1'b1;
               dsu_req.dividend  = {cur_mag[20:0], 16'd0} & {DVD_W{1'b1}};
               dsu_req.divisor   = len_ff;
               state_in          = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (dsu_rsp.done) begin
               if (vsel_ff) begin
                  vu_in[k_ff] = cur[21] ? -18'(dsu_rsp.quotient) : 18'(dsu_rsp.quotient);
               end else begin
                  lu_in[k_ff] = cur[21] ? -18'(dsu_rsp.quotient) : 18'(dsu_rsp.quotient);
               end
               advance = 1'b1;
            end
         end
         ST_DOT_D: begin
            acc_in = ((k_ff == 2'd0) ? 50'sd0 : acc_ff) + $signed(prod[49:0]);
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = ST_D_FIN;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_D_FIN: begin
            d_in     = q16[22:0];
            state_in = ST_RF;
         end
         ST_RF: begin
            // Reflect the reversed light direction about the normal
            q16         = div_q16(prod <<< 1);
            rf_in[k_ff] = q16[29:0] - 30'(lu_ff[k_ff]);
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = ST_DOT_S;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_DOT_S: begin
            acc_in = ((k_ff == 2'd0) ? 50'sd0 : acc_ff) + $signed(prod[49:0]);
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = ST_S_FIN;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_S_FIN: begin
            // Saturate the specular base to zero .. 1.0
            if (q16[65]) begin
               s_in = '0;
            end else if (q16 > 66'sd65536) begin
               s_in = ONE_Q16;
            end else begin
               s_in = q16[16:0];
            end
            p_in     = ONE_Q16;
            cnt_in   = '0;
            state_in = ST_POW;
         end
         ST_POW: begin
            if (cnt_ff == cfg.shininess) begin
               state_in = ST_FAC;
            end else begin
               p_in   = prod[32:16];
               cnt_in = cnt_ff + 8'd1;
            end
         end
         ST_FAC: begin
            factor_in = 24'(prod[32:15]) + 24'(kd);
            state_in  = ST_BRIGHT;
         end
         ST_BRIGHT: begin
            bright_in = prod[31:0];
            k_in      = 2'd0;
            state_in  = ST_C1;
         end
         ST_C1: begin
            c1_in    = prod[39:15];
            state_in = ST_C2;
         end
         ST_C2: begin
            // Accumulate with saturation
            sat_sum      = {1'b0, sum_ff[k_ff]} + 33'(prod[56:27]);
            sum_in[k_ff] = sat_sum[32] ? SAT32 : sat_sum[31:0];
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = ST_FINAL;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_C1;
            end
         end
         ST_FINAL: begin
            k_in     = 2'd0;
            state_in = last_ff ? ST_AMB : ST_IDLE;
         end
         ST_AMB: begin
            sat_sum  = {1'b0, sum_ff[k_ff]} + 33'({amb_k, 1'b0});
            tot_in   = sat_sum[32] ? SAT32 : sat_sum[31:0];
            state_in = ST_ALB;
         end
         ST_ALB: begin
            // Apply albedo, clamp to 1.0 and clear the channel
            out_in[k_ff] = (alb_prod > 32'(ONE_Q15)) ? ONE_Q15[CH_W-1:0] : alb_prod[CH_W-1:0];
            sum_in[k_ff] = '0;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = ST_EMIT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_AMB;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Step to the next component, then to the view vector
      if (advance) begin
         if (k_ff == 2'd2) begin
            k_in = 2'd0;
            if (vsel_ff) begin
               state_in = ST_DOT_D;
            end else begin
               vsel_in  = 1'b1;
               state_in = ST_SQ;
            end
         end else begin
            k_in     = k_ff + 2'd1;
            state_in = ST_DIV_GO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
      k_ff      <= k_in;
      vsel_ff   <= vsel_in;
      last_ff   <= last_in;
      ratio_ff  <= ratio_in;
      acc_ff    <= acc_in;
      len_ff    <= len_in;
      d_ff      <= d_in;
      s_ff      <= s_in;
      p_ff      <= p_in;
      cnt_ff    <= cnt_in;
      factor_ff <= factor_in;
      bright_ff <= bright_in;
      c1_ff     <= c1_in;
      tot_ff    <= tot_in;
      for (int i = 0; i < 3; i++) begin
         nrm_ff[i] <= nrm_in[i];
         ld_ff[i]  <= ld_in[i];
         vw_ff[i]  <= vw_in[i];
         lu_ff[i]  <= lu_in[i];
         vu_ff[i]  <= vu_in[i];
         rf_ff[i]  <= rf_in[i];
         col_ff[i] <= col_in[i];
         alb_ff[i] <= alb_in[i];
         out_ff[i] <= out_in[i];
      end
   end

   assign result.valid = (state_ff == ST_EMIT);
   assign result.red   = out_ff[0];
   assign result.green = out_ff[1];
   assign result.blue  = out_ff[2];

endmodule

[tb/sv/plm_shading_monitor.sv]
// Watches the light and colour channels, predicts each hit colour and compares.
module plm_shading_monitor (
   input  logic                          clock,
   input  logic                          reset,
   plm_req_if                            req_mon,
   plm_rsp_if                            rsp_mon,
   input  logic                          csr_write_enable,
   input  logic [plm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plm_pkg::CH_W-1:0]      csr_write_data,
   output int                            fail_count,
   output int                            colours_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import plm_pkg::*;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } hit_colour_type;

   plm_cfg_type      shade_cfg;
   logic [SUM_W-1:0] light_sum [3];
   hit_colour_type   colour_queue [$];

   // Sign-extend one Q4.16 component of a packed vector
   function automatic longint vec_comp(logic [VEC_W-1:0] w, int k);
      logic signed [COMP_W-1:0] c;
      c = w[k*COMP_W +: COMP_W];
      return longint'(c);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scale a vector to unit length in Q.16; a zero vector stays zero
   function automatic void unit_vector(input longint a [3], output longint u [3]);
      longint unsigned len2;
      longint unsigned len;
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += longint'(a[i] * a[i]);
      len = floor_root(len2);
      for (int i = 0; i < 3; i++)
         u[i] = (len == 0) ? 0 : (a[i] * 65536) / longint'(len);
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > longint'(SAT32)) ? SAT32 : s[SUM_W-1:0];
   endfunction

   // Add the diffuse and specular share of one unshadowed light to the sums
   function automatic void accumulate_light(
      logic [VEC_W-1:0] hp_w, logic [VEC_W-1:0] nrm_w, logic [VEC_W-1:0] ray_w,
      logic [VEC_W-1:0] lp_w, logic [COL_W-1:0] colour, logic [CH_W-1:0] ratio);
      longint nrm [3], ldir [3], view [3], lu [3], vu [3], refl [3];
      longint d, s;
      longint unsigned pw, kd, factor, bright, col, c1, c2;
      for (int i = 0; i < 3; i++) begin
         nrm[i]  = vec_comp(nrm_w, i);
         ldir[i] = vec_comp(lp_w, i) - vec_comp(hp_w, i);
         view[i] = -vec_comp(ray_w, i);
      end
      unit_vector(ldir, lu);
      unit_vector(view, vu);
      d = 0;
      for (int i = 0; i < 3; i++) d += lu[i] * nrm[i];
      d = d / 65536;
      for (int i = 0; i < 3; i++) refl[i] = -lu[i] + (2 * d * nrm[i]) / 65536;
      s = 0;
      for (int i = 0; i < 3; i++) s += vu[i] * refl[i];
      s = s / 65536;
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
      pw = 65536;
      for (int k = 0; k < shade_cfg.shininess; k++) pw = (pw * longint'(s)) >> 16;
      kd = (d > 0) ? longint'(d) : 0;
      factor = ((pw * shade_cfg.specular_gain) >> 15) + kd;
      bright = longint'(ratio) * shade_cfg.lumen_gain;
      for (int c = 0; c < 3; c++) begin
         col = colour[c*CH_W +: CH_W];
         c1 = (factor * col) >> 15;
         c2 = (c1 * bright) >> 27;
         light_sum[c] = sat_add(light_sum[c], c2);
      end
   endfunction

   // Close a hit: ambient, albedo, clamp, then clear the sums
   function automatic hit_colour_type finish_hit(logic [COL_W-1:0] albedo);
      hit_colour_type   hc;
      logic [CH_W-1:0]  amb [3];
      logic [CH_W-1:0]  ch [3];
      longint unsigned  tot, v;
      amb[0] = shade_cfg.ambient_red;
      amb[1] = shade_cfg.ambient_green;
      amb[2] = shade_cfg.ambient_blue;
      for (int c = 0; c < 3; c++) begin
         tot = sat_add(light_sum[c], longint'(amb[c]) * 2);
         v = (tot * albedo[c*CH_W +: CH_W]) >> 16;
         if (v > 32768) v = 32768;
         ch[c] = v[CH_W-1:0];
         light_sum[c] = '0;
      end
      hc.red   = ch[0];
      hc.green = ch[1];
      hc.blue  = ch[2];
      return hc;
   endfunction

   always @(posedge clock) begin
      hit_colour_type want;
      if (reset) begin
         shade_cfg.ambient_red   = '0;
         shade_cfg.ambient_green = '0;
         shade_cfg.ambient_blue  = '0;
         shade_cfg.specular_gain = 16'd16384;
         shade_cfg.shininess     = 8'd64;
         shade_cfg.lumen_gain    = 16'd12288;
         for (int c = 0; c < 3; c++) light_sum[c] = '0;
         colour_queue.delete();
         fail_count = 0;
      end else begin
         // Mirror register writes
         if (csr_write_enable) begin
            case (csr_index)
               REG_AMBIENT_RED:   shade_cfg.ambient_red   = csr_write_data;
               REG_AMBIENT_GREEN: shade_cfg.ambient_green = csr_write_data;
               REG_AMBIENT_BLUE:  shade_cfg.ambient_blue  = csr_write_data;
               REG_SPECULAR_GAIN: shade_cfg.specular_gain = csr_write_data;
               REG_SHININESS:     shade_cfg.shininess     = csr_write_data[7:0];
               REG_LUMEN_GAIN:    shade_cfg.lumen_gain    = csr_write_data;
               default: ;
            endcase
         end
         // Predict on each light transaction
         if (req_mon.valid && req_mon.ready) begin
            if (!req_mon.shadowed)
               accumulate_light(req_mon.hit_point, req_mon.surface_normal, req_mon.ray_dir,
                                req_mon.light_pos, req_mon.light_colour, req_mon.light_ratio);
            if (req_mon.last_light) colour_queue.push_back(finish_hit(req_mon.albedo));
         end
         // Compare each colour transaction with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (colour_queue.size() == 0) begin
               fail_count++;
               $display("%t unexpected colour r=%0d g=%0d b=%0d", $realtime,
                        rsp_mon.out_red, rsp_mon.out_green, rsp_mon.out_blue);
            end else begin
               want = colour_queue.pop_front();
               if (rsp_mon.out_red !== want.red) begin
                  fail_count++;
                  $display("%t red mismatch: expected %0d, got %0d", $realtime,
                           want.red, rsp_mon.out_red);
               end
               if (rsp_mon.out_green !== want.green) begin
                  fail_count++;
                  $display("%t green mismatch: expected %0d, got %0d", $realtime,
                           want.green, rsp_mon.out_green);
               end
               if (rsp_mon.out_blue !== want.blue) begin
                  fail_count++;
                  $display("%t blue mismatch: expected %0d, got %0d", $realtime,
                           want.blue, rsp_mon.out_blue);
               end
            end
         end
      end
      colours_pending = colour_queue.size();
   end

endmodule

[tb/sv/phong_light_accumulator_tb.sv]
// Stimulus and verdict for the Phong light accumulator.
module phong_light_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plm_pkg::*;

   typedef struct {
      logic [VEC_W-1:0] hit_point;
      logic [VEC_W-1:0] surface_normal;
      logic [VEC_W-1:0] ray_dir;
      logic [VEC_W-1:0] light_pos;
      logic [COL_W-1:0] light_colour;
      logic [CH_W-1:0]  light_ratio;
      logic [COL_W-1:0] albedo;
      logic             shadowed;
      logic             last_light;
   } light_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CH_W-1:0]      csr_write_data;
   int                   fail_count;
   int                   colours_pending;
   bit                   send_eager;
   int                   colours_taken;

   plm_req_if req_ch ();
   plm_rsp_if rsp_ch ();

   phong_light_accumulator dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   plm_shading_monitor shading_mon (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .colours_pending  (colours_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
      logic [COMP_W-1:0] cx, cy, cz;
      cx = x[COMP_W-1:0];
      cy = y[COMP_W-1:0];
      cz = z[COMP_W-1:0];
      return {cz, cy, cx};
   endfunction

   function automatic logic [VEC_W-1:0] any_vec();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[VEC_W-1:0];
   endfunction

   function automatic logic [COL_W-1:0] any_colour();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[COL_W-1:0];
   endfunction

   // Point within a few units of the origin
   function automatic logic [VEC_W-1:0] scene_vec();
      return pack_vec($urandom_range(0, 524288) - 262144, $urandom_range(0, 524288) - 262144,
                      $urandom_range(0, 524288) - 262144);
   endfunction

   // Mostly an axis-aligned unit normal, sometimes an arbitrary one
   function automatic logic [VEC_W-1:0] pick_normal();
      int sel;
      int sgn;
      sel = $urandom_range(0, 9);
      sgn = $urandom_range(0, 1) ? 65536 : -65536;
      case (sel)
         0, 1, 2: return pack_vec(0, 0, sgn);
         3, 4:    return pack_vec(0, sgn, 0);
         5, 6:    return pack_vec(sgn, 0, 0);
         7:       return pack_vec($urandom_range(0, 131072) - 65536,
                                  $urandom_range(0, 131072) - 65536,
                                  $urandom_range(0, 131072) - 65536);
         default: return any_vec();
      endcase
   endfunction

   // Offer one light and hold it until the block takes it
   task automatic offer_light(light_type l);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.hit_point      = l.hit_point;
      req_ch.surface_normal = l.surface_normal;
      req_ch.ray_dir        = l.ray_dir;
      req_ch.light_pos      = l.light_pos;
      req_ch.light_colour   = l.light_colour;
      req_ch.light_ratio    = l.light_ratio;
      req_ch.albedo         = l.albedo;
      req_ch.shadowed       = l.shadowed;
      req_ch.last_light     = l.last_light;
      req_ch.valid          = 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   // One surface hit: a run of lights, the final one marked (noisy hits may set the mark at random)
   task automatic shade_hit(int lights, bit noisy);
      light_type l;
      logic [VEC_W-1:0] hp, nrm, ray;
      logic [COL_W-1:0] alb;
      hp  = noisy ? any_vec() : scene_vec();
      nrm = noisy ? any_vec() : pick_normal();
      ray = noisy ? any_vec() : scene_vec();
      alb = any_colour();
      for (int i = 0; i < lights; i++) begin
         l.hit_point      = hp;
         l.surface_normal = nrm;
         l.ray_dir        = ray;
         l.light_pos      = noisy ? any_vec() : scene_vec();
         l.light_colour   = any_colour();
         l.light_ratio    = ($urandom_range(0, 7) == 0) ? 16'd32768
                                                        : 16'($urandom_range(0, 32768));
         l.albedo         = alb;
         l.shadowed       = ($urandom_range(0, 4) == 0);
         l.last_light     = (i == lights - 1);
         if (noisy && $urandom_range(0, 3) == 0) l.last_light = 1'($urandom_range(0, 1));
         offer_light(l);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value[CH_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Wait for every colour, then let a lone unfinished light drain
   task automatic settle();
      req_ch.valid = 1'b0;
      while (colours_pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic random_phase(int hits);
      send_eager = ($urandom_range(0, 3) == 0);
      for (int h = 0; h < hits; h++) begin
         // Pause halfway until the block has delivered everything
         if (h == hits / 2) begin
            req_ch.valid = 1'b0;
            while (colours_pending != 0) @(negedge clock);
         end
         shade_hit($urandom_range(1, 4), $urandom_range(0, 9) == 0);
      end
      send_eager = 1'b0;
      settle();
   endtask

   // Colour receiver: random stalls, eager stretches, one long hold
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      colours_taken = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && colours_taken == 20) begin
            held = 1'b1;
            rsp_ch.ready = 1'b0;
            repeat (3000) @(negedge clock);
         end
         stall = ((colours_taken / 30) % 3 == 1) ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         colours_taken++;
         @(negedge clock);
      end
   end

   initial begin
      light_type l;
      req_ch.valid = 1'b0;
      req_ch.hit_point = '0;
      req_ch.surface_normal = '0;
      req_ch.ray_dir = '0;
      req_ch.light_pos = '0;
      req_ch.light_colour = '0;
      req_ch.light_ratio = '0;
      req_ch.albedo = '0;
      req_ch.shadowed = 1'b0;
      req_ch.last_light = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      send_eager = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lights at the default register values
      l.hit_point      = pack_vec(0, 0, 0);
      l.surface_normal = pack_vec(0, 0, 65536);
      l.ray_dir        = pack_vec(0, 65536, -65536);
      l.light_pos      = pack_vec(65536, 131072, 196608);
      l.light_colour   = {16'd32768, 16'd32768, 16'd32768};
      l.light_ratio    = 16'd32768;
      l.albedo         = {16'd40000, 16'd20000, 16'd65535};
      l.shadowed       = 1'b0;
      l.last_light     = 1'b0;
      offer_light(l);
      // light sitting on the hit point
      l.light_pos = l.hit_point;
      offer_light(l);
      // zero view direction
      l.light_pos = pack_vec(0, 0, 65536);
      l.ray_dir   = pack_vec(0, 0, 0);
      offer_light(l);
      // unnormalized normal
      l.surface_normal = pack_vec(30000, -70000, 200000);
      l.ray_dir        = pack_vec(0, 0, -65536);
      offer_light(l);
      l.shadowed = 1'b1;
      offer_light(l);
      l.last_light = 1'b1;
      offer_light(l);
      // zero brightness on the last light
      l.shadowed    = 1'b0;
      l.light_ratio = 16'd0;
      offer_light(l);
      // full colour, full albedo
      l.light_ratio  = 16'd32768;
      l.light_colour = '1;
      l.albedo       = '1;
      offer_light(l);
      // all-ones vectors, then component extremes
      l.hit_point      = '1;
      l.surface_normal = '1;
      l.ray_dir        = '1;
      l.light_pos      = '1;
      l.last_light     = 1'b0;
      offer_light(l);
      l.hit_point      = pack_vec(-1048576, -1048576, -1048576);
      l.light_pos      = pack_vec(1048575, 1048575, 1048575);
      l.surface_normal = pack_vec(1048575, 1048575, 1048575);
      l.ray_dir        = pack_vec(-1048576, -1048576, -1048576);
      offer_light(l);
      l.hit_point      = pack_vec(1048575, 1048575, 1048575);
      l.light_pos      = pack_vec(-1048576, -1048576, -1048576);
      l.surface_normal = pack_vec(-1048576, -1048576, -1048576);
      l.last_light     = 1'b1;
      offer_light(l);
      settle();

      // Upper extremes, with a saturating burst from a huge normal
      write_reg(REG_AMBIENT_RED, 32768);
      write_reg(REG_AMBIENT_GREEN, 32768);
      write_reg(REG_AMBIENT_BLUE, 32768);
      write_reg(REG_SPECULAR_GAIN, 32768);
      write_reg(REG_SHININESS, 255);
      write_reg(REG_LUMEN_GAIN, 65535);
      write_reg(3'd6, 16'hFFFF);
      write_reg(3'd7, 16'h1234);
      l.hit_point      = pack_vec(0, 0, 0);
      l.surface_normal = pack_vec(0, 0, 1048575);
      l.ray_dir        = pack_vec(0, 0, -65536);
      l.light_pos      = pack_vec(0, 0, 65536);
      l.light_colour   = '1;
      l.light_ratio    = 16'd32768;
      l.albedo         = '1;
      l.shadowed       = 1'b0;
      for (int i = 0; i < 12; i++) begin
         l.last_light = (i == 11);
         offer_light(l);
      end
      settle();
      random_phase(40);

      // Lower extremes
      write_reg(REG_AMBIENT_RED, 0);
      write_reg(REG_AMBIENT_GREEN, 0);
      write_reg(REG_AMBIENT_BLUE, 0);
      write_reg(REG_SPECULAR_GAIN, 0);
      write_reg(REG_SHININESS, 1);
      write_reg(REG_LUMEN_GAIN, 0);
      random_phase(40);
      // zero exponent written through the eight-bit field
      write_reg(REG_SHININESS, 16'hFF00);
      write_reg(REG_LUMEN_GAIN, 65535);
      write_reg(REG_SPECULAR_GAIN, 32768);
      random_phase(30);

      // Random settings, mostly low exponents to keep the run short
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_AMBIENT_RED, $urandom_range(0, 32768));
         write_reg(REG_AMBIENT_GREEN, $urandom_range(0, 32768));
         write_reg(REG_AMBIENT_BLUE, $urandom_range(0, 32768));
         write_reg(REG_SPECULAR_GAIN, $urandom_range(0, 32768));
         write_reg(REG_SHININESS, (p == 2) ? $urandom_range(100, 255) : $urandom_range(1, 24));
         write_reg(REG_LUMEN_GAIN, $urandom_range(0, 65535));
         random_phase(37);
      end

      settle();
      if (fail_count == 0 && colours_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
